// File: sv/assert_macros.svh
// Assertion helper macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/mtmf_pkg.sv
package mtmf_pkg;

   localparam int unsigned CHANNELS_DEF  = 64;
   localparam int unsigned HISTORY_DEF   = 8;
   localparam int unsigned KEEP_DEF      = 4;
   localparam int unsigned CH_W          = 6;
   localparam int unsigned SAMPLE_W      = 16;
   localparam logic [SAMPLE_W-1:0] THRESH_RESET = 16'd4;

   // Item passed from the front part to the back part
   typedef struct packed {
      logic [CH_W-1:0]     channel;
      logic [SAMPLE_W-1:0] sample;
   } job_type;

endpackage

// File: sv/mtmf_front.sv
// Input queue: two entry buffer between the request port and the engine
module mtmf_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mtmf_pkg::job_type push_job,
   output logic             full,
   output logic             job_valid,
   output mtmf_pkg::job_type job,
   input  logic             job_take
);
   import mtmf_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign job_valid = (count_ff != 2'd0);
   assign job       = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = job_take && job_valid;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload store
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: sv/mtmf_back.sv
// Engine: clear, history load/shift, sort, sum, divide, deadband, output register
module mtmf_back #(
   parameter int unsigned CHANNELS = mtmf_pkg::CHANNELS_DEF,
   parameter int unsigned HISTORY  = mtmf_pkg::HISTORY_DEF,
   parameter int unsigned KEEP     = mtmf_pkg::KEEP_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  mtmf_pkg::job_type             job,
   output logic                          job_take,
   input  logic [mtmf_pkg::SAMPLE_W-1:0] threshold,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [mtmf_pkg::CH_W-1:0]     rsp_out_channel,
   output logic [mtmf_pkg::SAMPLE_W-1:0] rsp_filtered,
   output logic                          rsp_held
);
   import mtmf_pkg::*;

   localparam int unsigned KEEP_EFF = (KEEP > HISTORY) ? HISTORY : KEEP;
   localparam int unsigned TRIM     = (HISTORY - KEEP_EFF) / 2;
   localparam int unsigned CIDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned HIDX_W   = $clog2(HISTORY);
   localparam int unsigned FILL_W   = $clog2(HISTORY + 1);
   localparam int unsigned SUM_W    = SAMPLE_W + $clog2(HISTORY + 1);
   localparam int unsigned DCNT_W   = $clog2(SUM_W + 1);
   localparam int unsigned SCNT_W   = $clog2(HISTORY + 2);
   localparam int unsigned WORDS    = CHANNELS * HISTORY;
   localparam int unsigned ADDR_W   = $clog2(WORDS);
   localparam int unsigned CCNT_W   = $clog2(WORDS + 1);

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_LOAD  = 9'b000000100,
      S_WAIT  = 9'b000001000,
      S_SORT  = 9'b000010000,
      S_SUM   = 9'b000100000,
      S_DIV   = 9'b001000000,
      S_HOLD  = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // History memory, one word per channel slot
   logic [SAMPLE_W-1:0] hist_mem [WORDS];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [SAMPLE_W-1:0] wr_data;

   // Per-channel fill count and last output, one word per channel
   logic [FILL_W-1:0]   fill_mem [CHANNELS];
   logic [SAMPLE_W-1:0] last_mem [CHANNELS];
   logic [FILL_W-1:0]   fill_rd_ff;
   logic [SAMPLE_W-1:0] last_rd_ff;
   logic                meta_we;
   logic [CIDX_W-1:0]   meta_addr;
   logic [FILL_W-1:0]   meta_fill;
   logic [SAMPLE_W-1:0] meta_last;

   logic [CCNT_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [CH_W-1:0]     chin_ff, chin_in;
   logic [CIDX_W-1:0]   ch_ff, ch_in;
   logic [SAMPLE_W-1:0] win_ff [HISTORY];
   logic [SAMPLE_W-1:0] win_in [HISTORY];
   logic [HIDX_W:0]     idx_ff, idx_in;
   logic [SCNT_W-1:0]   pass_ff, pass_in;
   logic [FILL_W-1:0]   n_ff, n_in;
   logic                full_ff, full_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SUM_W-1:0]    rem_ff, rem_in;
   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic [DCNT_W-1:0]   dcnt_ff, dcnt_in;
   logic [SAMPLE_W-1:0] res_ff, res_in;
   logic                held_ff, held_in;
   logic [SUM_W:0]      trial;
   logic [SUM_W-1:0]    divisor;
   logic [SAMPLE_W-1:0] raw, last, diff;
   logic [CIDX_W-1:0]   job_ch;
   logic [CIDX_W-1:0]   ch_map [1 << CH_W];

   // Channel reduced modulo CHANNELS, as a constant table
   for (genvar c = 0; c < (1 << CH_W); c++) begin : g_ch_map
      assign ch_map[c] = CIDX_W'(c % CHANNELS);
   end
   assign job_ch = ch_map[job.channel];

   assign rsp_empty       = (state_ff != S_OUT);
   assign rsp_out_channel = chin_ff;
   assign rsp_filtered    = res_ff;
   assign rsp_held        = held_ff;
   assign job_take        = (state_ff == S_IDLE) && job_valid;
   assign divisor         = full_ff ? SUM_W'(KEEP_EFF) : SUM_W'(n_ff);
   assign trial           = {rem_ff, quo_ff[SUM_W-1]} - {1'b0, divisor};
   assign raw             = quo_ff[SAMPLE_W-1:0];
   assign last            = last_rd_ff;
   assign diff            = (raw >= last) ? raw - last : last - raw;
   assign rd_addr         = ADDR_W'(ch_ff * HISTORY + idx_ff[HIDX_W-1:0]);

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      chin_in    = chin_ff;
      ch_in      = ch_ff;
      win_in     = win_ff;
      idx_in     = idx_ff;
      pass_in    = pass_ff;
      n_in       = n_ff;
      full_in    = full_ff;
      sum_in     = sum_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      dcnt_in    = dcnt_ff;
      res_in     = res_ff;
      held_in    = held_ff;
      wr_en      = 1'b0;
      wr_addr    = rd_addr;
      wr_data    = '0;
      meta_we    = 1'b0;
      meta_addr  = ch_ff;
      meta_fill  = '0;
      meta_last  = '0;
      case (state_ff)
         S_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = ADDR_W'(clr_cnt_ff);
            meta_we    = (clr_cnt_ff < CCNT_W'(CHANNELS));
            meta_addr  = CIDX_W'(clr_cnt_ff);
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CCNT_W'(WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (job_valid) begin
               chin_in   = job.channel;
               ch_in     = job_ch;
               win_in[0] = job.sample;
               idx_in    = '0;
               state_in  = S_LOAD;
            end
         end
         // Issue reads for the HISTORY-1 newest stored words
         S_LOAD: begin
            if (HISTORY > 1) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            win_in[HIDX_W'(idx_ff + 1'b1)] = rd_data_ff;
            if (idx_ff == (HIDX_W + 1)'(HISTORY - 2)) begin
               full_in  = (fill_rd_ff == FILL_W'(HISTORY));
               n_in     = (fill_rd_ff == FILL_W'(HISTORY)) ? FILL_W'(HISTORY)
                                                           : fill_rd_ff + 1'b1;
               pass_in  = '0;
               idx_in   = '0;
               state_in = S_SORT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_LOAD;
            end
         end
         // Write back shifted history one word per cycle; odd-even sort passes if full
         S_SORT: begin
            if (idx_ff < (HIDX_W + 1)'(HISTORY)) begin
               wr_en   = 1'b1;
               wr_data = win_ff[idx_ff[HIDX_W-1:0]];
               idx_in  = idx_ff + 1'b1;
            end else if (!full_ff || pass_ff == SCNT_W'(HISTORY)) begin
               sum_in   = '0;
               idx_in   = full_ff ? (HIDX_W + 1)'(TRIM) : '0;
               state_in = S_SUM;
            end else begin
               for (int i = 0; i + 1 < HISTORY; i++) begin
                  if ((i % 2) == int'(pass_ff[0]) && win_ff[i] > win_ff[i + 1]) begin
                     win_in[i]     = win_ff[i + 1];
                     win_in[i + 1] = win_ff[i];
                  end
               end
               pass_in = pass_ff + 1'b1;
            end
         end
         S_SUM: begin
            sum_in = sum_ff + SUM_W'(win_ff[idx_ff[HIDX_W-1:0]]);
            idx_in = idx_ff + 1'b1;
            if (full_ff ? (idx_ff == (HIDX_W + 1)'(TRIM + KEEP_EFF - 1))
                        : (idx_ff == (HIDX_W + 1)'(n_ff - 1'b1))) begin
               rem_in   = '0;
               quo_in   = sum_in;
               dcnt_in  = '0;
               state_in = S_DIV;
            end
         end
         // Restoring divide, one quotient bit per cycle
         S_DIV: begin
            if (!trial[SUM_W]) begin
               rem_in = trial[SUM_W-1:0];
               quo_in = {quo_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[SUM_W-2:0], quo_ff[SUM_W-1]};
               quo_in = {quo_ff[SUM_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_W'(SUM_W - 1)) begin
               state_in = S_HOLD;
            end
         end
         // Deadband, then store fill count and output for the channel
         S_HOLD: begin
            held_in   = (diff < threshold);
            res_in    = (diff < threshold) ? last : raw;
            meta_we   = 1'b1;
            meta_fill = n_ff;
            meta_last = res_in;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (rsp_pop) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      chin_ff <= chin_in;
      ch_ff   <= ch_in;
      win_ff  <= win_in;
      idx_ff  <= idx_in;
      pass_ff <= pass_in;
      n_ff    <= n_in;
      full_ff <= full_in;
      sum_ff  <= sum_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dcnt_ff <= dcnt_in;
      res_ff  <= res_in;
      held_ff <= held_in;
   end

   // History memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= hist_mem[rd_addr];
   end

   // Fill count and last output memory ports
   always_ff @(posedge clock) begin
      if (meta_we) begin
         fill_mem[meta_addr] <= meta_fill;
         last_mem[meta_addr] <= meta_last;
      end
      fill_rd_ff <= fill_mem[ch_ff];
      last_rd_ff <= last_mem[ch_ff];
   end

endmodule

// File: sv/multichannel_trimmed_mean_filter_unit.sv
// Multichannel trimmed-mean filter.
// Request side: push req_channel/req_sample while full is low; a two item
// queue decouples the request port from the filter engine.
// Result side: while empty is low, rsp_out_channel, rsp_filtered and
// rsp_held show the result; pop takes it. One result per request, in order.
// Each channel keeps its newest HISTORY samples in a shared history memory
// with one read and one write port; the engine reads them one word at a
// time, writes back the shifted window, runs HISTORY odd-even sort passes
// once full, sums the kept middle values and divides one quotient bit a cycle.
// The engine handles one item at a time and takes the next only after
// its result is popped; word-serial load and write-back, the sort
// passes and the divide set the time per item.
// Reset: a clearing pass over CHANNELS*HISTORY words (512 by default) zeroes
// the history, fill counts and last outputs; the queue takes up to two
// items meanwhile, but the engine takes none until the pass ends.
// A stalled receiver holds the result in the output register; the queue
// then fills and full rises. csr_hold_threshold may be written at any idle time.
module multichannel_trimmed_mean_filter_unit #(
   parameter int unsigned CHANNELS = mtmf_pkg::CHANNELS_DEF,
   parameter int unsigned HISTORY  = mtmf_pkg::HISTORY_DEF,
   parameter int unsigned KEEP     = mtmf_pkg::KEEP_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [mtmf_pkg::CH_W-1:0]     req_channel,
   input  logic [mtmf_pkg::SAMPLE_W-1:0] req_sample,
   output logic                          empty,
   input  logic                          pop,
   output logic [mtmf_pkg::CH_W-1:0]     rsp_out_channel,
   output logic [mtmf_pkg::SAMPLE_W-1:0] rsp_filtered,
   output logic                          rsp_held,
   input  logic                          csr_we,
   input  logic [mtmf_pkg::SAMPLE_W-1:0] csr_hold_threshold
);
   import mtmf_pkg::*;

   job_type             push_job, job;
   logic                job_valid, job_take;
   logic [SAMPLE_W-1:0] thresh_ff;

   assign push_job.channel = req_channel;
   assign push_job.sample  = req_sample;

   // Threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_we) begin
         thresh_ff <= csr_hold_threshold;
      end
   end

   mtmf_front u_front (
      .clock, .reset, .push, .push_job, .full,
      .job_valid, .job, .job_take
   );

   mtmf_back #(.CHANNELS(CHANNELS), .HISTORY(HISTORY), .KEEP(KEEP)) u_back (
      .clock, .reset, .job_valid, .job, .job_take,
      .threshold(thresh_ff),
      .rsp_empty(empty), .rsp_pop(pop),
      .rsp_out_channel, .rsp_filtered, .rsp_held
   );

endmodule

// File: sv/mtmf_checker.sv
// Port-level checks on the filter unit
module mtmf_checker (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input logic [5:0] rsp_out_channel,
   input logic       rsp_held
);
`include "assert_macros.svh"

   `ASSERT_NEXT(a_rsp_holds, clock, reset, (!empty && !pop), (!empty && $stable(rsp_out_channel)), "result dropped while stalled")
   `ASSERT_NEXT(a_pop_clears, clock, reset, (!empty && pop), empty, "result repeated after pop")
   `ASSERT_IMPL(a_no_empty_rst, clock, 1'b0, $past(reset), empty, "result shown right after reset")
   `ASSERT_IMPL(a_no_full_rst, clock, 1'b0, $past(reset), !full, "queue full right after reset")
   `ASSERT_IMPL(a_held_known, clock, reset, !empty, (rsp_held == 1'b0 || rsp_held == 1'b1), "held flag unknown")

endmodule

bind multichannel_trimmed_mean_filter_unit mtmf_checker u_mtmf_checker (
   .clock, .reset, .full, .empty, .pop, .rsp_out_channel, .rsp_held
);
